// ===== rtl/core/gra_pkg.sv =====
// ----------------------------------------------------------------------------
// gra_pkg
// Shared types and constants of the guillotine rectangle allocator.
// ----------------------------------------------------------------------------
package gra_pkg;

  localparam int unsigned MAX_FREE_RECTS = 64;
  localparam int unsigned COORD_BITS     = 13;
  localparam int unsigned IDX_W          = $clog2(MAX_FREE_RECTS);
  localparam int unsigned CNT_W          = IDX_W + 1;
  localparam int unsigned PLACE_W        = 12;
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned ATLAS_LIMIT    = 4096;
  localparam int unsigned ATLAS_RESET    = 1024;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_NOFIT = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic {
    MODE_CLEAR = 1'b0,
    MODE_ALLOC = 1'b1
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FSM_INIT,
    FSM_IDLE,
    FSM_WALK,
    FSM_SPLIT,
    FSM_LINK,
    FSM_RESP
  } fsm_e;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } rect_t;

endpackage

// ===== rtl/core/guillotine_rect_allocator.sv =====
// ----------------------------------------------------------------------------
// guillotine_rect_allocator
// First-fit guillotine allocator over a linked free list held in memories.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) carries mode, req_width, req_height.
// Mode clear restores one free rectangle covering the atlas; mode allocate
// walks the free list from the head for the first rectangle that fits,
// splits it in place, or unlinks it on an exact fit, and returns its corner.
// Output channel (out_valid_o / out_stall_i) returns status, place_x,
// place_y and free_count, one result per transfer, through an output register.
// Configuration channel (cfg_valid_i / cfg_ready_o) sets atlas width and
// height; the values take effect at the next clear. It is always ready.
// A clear or empty request goes straight to the response; an allocate walks
// the list one entry per cycle, paced by the registered read of the
// rectangle memory, and a split that needs a spare entry adds the SPLIT and
// LINK states. One item is processed at a time.
// Reset spends one cycle writing the initial atlas entry before the first
// transfer. A stalled output holds its result and the block waits with it.
// ----------------------------------------------------------------------------
module guillotine_rect_allocator (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              mode_i,
  input  logic [gra_pkg::COORD_BITS-1:0]    req_width_i,
  input  logic [gra_pkg::COORD_BITS-1:0]    req_height_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [gra_pkg::STATUS_W-1:0]      status_o,
  output logic [gra_pkg::PLACE_W-1:0]       place_x_o,
  output logic [gra_pkg::PLACE_W-1:0]       place_y_o,
  output logic [gra_pkg::CNT_W-1:0]         free_count_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [gra_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [gra_pkg::COORD_BITS-1:0]    cfg_data_i
);
  import gra_pkg::*;

  localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_FREE_RECTS);
  localparam logic [COORD_BITS-1:0] AtlasLim = COORD_BITS'(ATLAS_LIMIT);

  fsm_e state_q, state_d;

  // memories
  rect_t                rect_mem [MAX_FREE_RECTS];
  logic [IDX_W-1:0]     link_mem [MAX_FREE_RECTS];
  logic [IDX_W-1:0]     pool_mem [MAX_FREE_RECTS];
  rect_t                rect_rd;
  logic [IDX_W-1:0]     link_rd;
  logic [IDX_W-1:0]     pool_rd;

  logic                 rect_we, link_we, pool_we;
  logic [IDX_W-1:0]     rect_waddr, link_waddr, pool_waddr, rd_addr, pool_raddr;
  rect_t                rect_wdata;
  logic [IDX_W-1:0]     link_wdata, pool_wdata;

  logic [MAX_FREE_RECTS-1:0] pool_vld_q, pool_vld_d;
  logic [IDX_W-1:0]     pool_raddr_q;

  logic [COORD_BITS-1:0] atlas_w_q, atlas_h_q, cfg_sat;
  logic [COORD_BITS-1:0] rw_q, rw_d, rh_q, rh_d;
  logic [IDX_W-1:0]     head_q, head_d, idx_q, idx_d, prev_q, prev_d;
  logic [IDX_W-1:0]     link_sav_q, link_sav_d, j_q, j_d, spare_j;
  logic                 has_prev_q, has_prev_d;
  logic [CNT_W-1:0]     live_q, live_d, cnt_q, cnt_d;
  rect_t                p1_q, p1_d;
  status_e              res_status_q, res_status_d;
  logic [PLACE_W-1:0]   res_x_q, res_x_d, res_y_q, res_y_d;

  logic                 out_valid_q;
  logic [STATUS_W-1:0]  status_q;
  logic [PLACE_W-1:0]   place_x_q, place_y_q;
  logic [CNT_W-1:0]     free_count_q;

  logic                 in_xfer, out_free, fits, wide_cut;
  logic [COORD_BITS-1:0] dx, dy;
  rect_t                piece0, piece1;
  logic [1:0]           n_pieces;

  assign in_stall_o   = (state_q != FSM_IDLE);
  assign in_xfer      = in_valid_i && !in_stall_o;
  assign out_free     = !out_valid_q || !out_stall_i;
  assign cfg_ready_o  = 1'b1;
  assign cfg_sat      = (cfg_data_i > AtlasLim) ? AtlasLim : cfg_data_i;

  // piece computation on the entry under the walk
  assign fits     = (rect_rd.w >= rw_q) && (rect_rd.h >= rh_q);
  assign dx       = rect_rd.w - rw_q;
  assign dy       = rect_rd.h - rh_q;
  assign wide_cut = dx > dy;
  assign spare_j  = pool_vld_q[pool_raddr_q] ? pool_rd : pool_raddr_q + IDX_W'(1);

  always_comb begin
    piece0   = '0;
    piece1   = '0;
    n_pieces = 2'd0;
    if (wide_cut) begin
      if (dy != '0) begin
        piece0   = '{x: rect_rd.x, y: rect_rd.y + rh_q, w: rw_q, h: dy};
        piece1   = '{x: rect_rd.x + rw_q, y: rect_rd.y, w: dx, h: rect_rd.h};
        n_pieces = 2'd2;
      end else begin
        piece0   = '{x: rect_rd.x + rw_q, y: rect_rd.y, w: dx, h: rect_rd.h};
        n_pieces = 2'd1;
      end
    end else if (dx != '0) begin
      piece0 = '{x: rect_rd.x + rw_q, y: rect_rd.y, w: dx, h: rh_q};
      if (dy != '0) begin
        piece1   = '{x: rect_rd.x, y: rect_rd.y + rh_q, w: rect_rd.w, h: dy};
        n_pieces = 2'd2;
      end else begin
        n_pieces = 2'd1;
      end
    end else if (dy != '0) begin
      piece0   = '{x: rect_rd.x, y: rect_rd.y + rh_q, w: rect_rd.w, h: dy};
      n_pieces = 2'd1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_INIT: state_d = FSM_IDLE;
      FSM_IDLE: begin
        if (in_xfer) begin
          if (mode_i == MODE_ALLOC && req_width_i != '0 && req_height_i != '0 &&
              live_q != '0) begin
            state_d = FSM_WALK;
          end else begin
            state_d = FSM_RESP;
          end
        end
      end
      FSM_WALK: begin
        if (fits) begin
          if (n_pieces == 2'd2 && live_q < MaxCnt) begin
            state_d = FSM_SPLIT;
          end else begin
            state_d = FSM_RESP;
          end
        end else if (cnt_q + CNT_W'(1) == live_q) begin
          state_d = FSM_RESP;
        end
      end
      FSM_SPLIT: state_d = FSM_LINK;
      FSM_LINK:  state_d = FSM_RESP;
      FSM_RESP: begin
        if (out_free) begin
          state_d = FSM_IDLE;
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    rect_we      = 1'b0;
    rect_waddr   = '0;
    rect_wdata   = '0;
    link_we      = 1'b0;
    link_waddr   = '0;
    link_wdata   = '0;
    pool_we      = 1'b0;
    pool_waddr   = '0;
    pool_wdata   = '0;
    rd_addr      = idx_q;
    pool_raddr   = pool_raddr_q;
    pool_vld_d   = pool_vld_q;
    rw_d         = rw_q;
    rh_d         = rh_q;
    head_d       = head_q;
    idx_d        = idx_q;
    prev_d       = prev_q;
    has_prev_d   = has_prev_q;
    link_sav_d   = link_sav_q;
    j_d          = j_q;
    live_d       = live_q;
    cnt_d        = cnt_q;
    p1_d         = p1_q;
    res_status_d = res_status_q;
    res_x_d      = res_x_q;
    res_y_d      = res_y_q;
    unique case (state_q)
      FSM_INIT: begin
        rect_we    = 1'b1;
        rect_wdata = '{x: '0, y: '0, w: COORD_BITS'(ATLAS_RESET),
                       h: COORD_BITS'(ATLAS_RESET)};
        link_we    = 1'b1;
      end
      FSM_IDLE: begin
        res_status_d = STAT_NOFIT;
        res_x_d      = '0;
        res_y_d      = '0;
        rw_d         = req_width_i;
        rh_d         = req_height_i;
        rd_addr      = head_q;
        idx_d        = head_q;
        cnt_d        = '0;
        has_prev_d   = 1'b0;
        if (in_xfer && mode_i == MODE_CLEAR) begin
          rect_we      = 1'b1;
          rect_wdata   = '{x: '0, y: '0, w: atlas_w_q, h: atlas_h_q};
          link_we      = 1'b1;
          head_d       = '0;
          live_d       = CNT_W'(1);
          pool_vld_d   = '0;
          res_status_d = STAT_OK;
        end
      end
      FSM_WALK: begin
        if (fits) begin
          if (n_pieces == 2'd2 && live_q >= MaxCnt) begin
            res_status_d = STAT_FULL;
          end else begin
            res_status_d = STAT_OK;
            res_x_d      = rect_rd.x[PLACE_W-1:0];
            res_y_d      = rect_rd.y[PLACE_W-1:0];
            unique case (n_pieces)
              2'd0: begin
                if (has_prev_q) begin
                  link_we    = 1'b1;
                  link_waddr = prev_q;
                  link_wdata = link_rd;
                end else begin
                  head_d = link_rd;
                end
                live_d                 = live_q - CNT_W'(1);
                pool_we                = 1'b1;
                pool_waddr             = IDX_W'(MaxCnt - live_q);
                pool_wdata             = idx_q;
                pool_vld_d[pool_waddr] = 1'b1;
              end
              2'd1: begin
                rect_we    = 1'b1;
                rect_waddr = idx_q;
                rect_wdata = piece0;
              end
              default: begin
                rect_we    = 1'b1;
                rect_waddr = idx_q;
                rect_wdata = piece0;
                p1_d       = piece1;
                link_sav_d = link_rd;
                pool_raddr = IDX_W'(MaxCnt - CNT_W'(1) - live_q);
              end
            endcase
          end
        end else begin
          prev_d     = idx_q;
          has_prev_d = 1'b1;
          idx_d      = link_rd;
          rd_addr    = link_rd;
          cnt_d      = cnt_q + CNT_W'(1);
        end
      end
      FSM_SPLIT: begin
        rect_we    = 1'b1;
        rect_waddr = spare_j;
        rect_wdata = p1_q;
        link_we    = 1'b1;
        link_waddr = spare_j;
        link_wdata = link_sav_q;
        j_d        = spare_j;
        live_d     = live_q + CNT_W'(1);
      end
      FSM_LINK: begin
        link_we    = 1'b1;
        link_waddr = idx_q;
        link_wdata = j_q;
      end
      FSM_RESP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (rect_we) begin
      rect_mem[rect_waddr] <= rect_wdata;
    end
    rect_rd <= rect_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    link_rd <= link_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (pool_we) begin
      pool_mem[pool_waddr] <= pool_wdata;
    end
    pool_rd <= pool_mem[pool_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= FSM_INIT;
      atlas_w_q    <= COORD_BITS'(ATLAS_RESET);
      atlas_h_q    <= COORD_BITS'(ATLAS_RESET);
      head_q       <= '0;
      live_q       <= CNT_W'(1);
      pool_vld_q   <= '0;
      pool_raddr_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      head_q       <= head_d;
      live_q       <= live_d;
      pool_vld_q   <= pool_vld_d;
      pool_raddr_q <= pool_raddr;
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_WIDTH) begin
          atlas_w_q <= cfg_sat;
        end else if (cfg_index_i == CFG_HEIGHT) begin
          atlas_h_q <= cfg_sat;
        end
      end
      if (state_q == FSM_RESP && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rw_q         <= rw_d;
    rh_q         <= rh_d;
    idx_q        <= idx_d;
    prev_q       <= prev_d;
    has_prev_q   <= has_prev_d;
    link_sav_q   <= link_sav_d;
    j_q          <= j_d;
    cnt_q        <= cnt_d;
    p1_q         <= p1_d;
    res_status_q <= res_status_d;
    res_x_q      <= res_x_d;
    res_y_q      <= res_y_d;
    if (state_q == FSM_RESP && out_free) begin
      status_q     <= res_status_q;
      place_x_q    <= res_x_q;
      place_y_q    <= res_y_q;
      free_count_q <= live_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign place_x_o    = place_x_q;
  assign place_y_o    = place_y_q;
  assign free_count_o = free_count_q;

endmodule
